FILE: rtl/bdch_pkg.sv
package bdch_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned AddrW  = 2;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // register indexes on the configuration port
  localparam logic [AddrW-1:0] RegDebounce = 2'd0;
  localparam logic [AddrW-1:0] RegWindow   = 2'd1;
  localparam logic [AddrW-1:0] RegHold     = 2'd2;

  localparam logic [CfgW-1:0] DebounceRst = 16'd50;
  localparam logic [CfgW-1:0] WindowRst   = 16'd400;
  localparam logic [CfgW-1:0] HoldRst     = 16'd800;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             pin_level;
  } item_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] multi_click_window_ms;
    logic [CfgW-1:0] hold_time_ms;
  } cfg_t;

  // packed order gives the tdata layout, last field in bit 0
  typedef struct packed {
    logic              triple_click;
    logic              double_click;
    logic              single_click;
    logic              hold_pulse;
    logic [CountW-1:0] press_count;
    logic              series_done_pulse;
    logic              click_pulse;
    logic              release_pulse;
    logic              press_pulse;
    logic              is_pressed;
  } result_t;

endpackage

FILE: rtl/bdch_in_stage.sv
module bdch_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bdch_pkg::InDataW-1:0]  in_tdata,
  input  logic                          advance,
  output logic                          valid,
  output bdch_pkg::item_t               item
);

  logic            valid_r;
  logic            valid_nxt;
  bdch_pkg::item_t item_r;
  logic            take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= bdch_pkg::item_t'(in_tdata[$bits(bdch_pkg::item_t)-1:0]);
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

FILE: rtl/bdch_core.sv
module bdch_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  bdch_pkg::item_t   item,
  input  bdch_pkg::cfg_t    cfg,
  output bdch_pkg::result_t res
);

  logic                        stable_level_r, stable_level_nxt;
  logic                        series_active_r, series_active_nxt;
  logic                        hold_active_r, hold_active_nxt;
  logic [bdch_pkg::TimeW-1:0]  last_change_time_r, last_change_time_nxt;
  logic [bdch_pkg::TimeW-1:0]  last_press_time_r, last_press_time_nxt;
  logic [bdch_pkg::CountW-1:0] series_count_r, series_count_nxt;

  logic                        raw_pressed;
  logic [bdch_pkg::TimeW-1:0]  dt_change;
  logic [bdch_pkg::TimeW-1:0]  dt_press;
  logic                        chg, press, release_ev, done, hold_fire;
  logic                        series_mid, hold_mid;

  assign raw_pressed = !item.pin_level;
  assign dt_change   = item.now_ms - last_change_time_r;
  assign dt_press    = item.now_ms - last_press_time_r;

  always_comb begin
    chg        = (stable_level_r != raw_pressed) &&
                 (dt_change >= {16'd0, cfg.debounce_ms});
    press      = chg && raw_pressed;
    release_ev = chg && !raw_pressed;

    stable_level_nxt     = chg ? raw_pressed : stable_level_r;
    last_change_time_nxt = chg ? item.now_ms : last_change_time_r;
    last_press_time_nxt  = press ? item.now_ms : last_press_time_r;
    hold_mid             = chg ? 1'b0 : hold_active_r;
    series_mid           = press ? 1'b1 : series_active_r;

    series_count_nxt = series_count_r;
    if (press) begin
      if (dt_press <= {16'd0, cfg.multi_click_window_ms}) begin
        if (series_count_r != bdch_pkg::CountMax) begin
          series_count_nxt = series_count_r + 8'd1;
        end
      end else begin
        series_count_nxt = 8'd1;
      end
    end

    // a press leaves the stable level high, so the old press delta is fine here
    done = !stable_level_nxt && series_mid &&
           (dt_press > {16'd0, cfg.multi_click_window_ms});

    // right after an accepted change the elapsed time is zero
    hold_fire = stable_level_nxt && !hold_mid &&
                ((chg ? '0 : dt_change) >= {16'd0, cfg.hold_time_ms});

    series_active_nxt = (done || hold_fire) ? 1'b0 : series_mid;
    hold_active_nxt   = hold_fire ? 1'b1 : hold_mid;
  end

  always_comb begin
    res.is_pressed        = stable_level_nxt;
    res.press_pulse       = press;
    res.release_pulse     = release_ev;
    res.click_pulse       = release_ev && !hold_active_r;
    res.series_done_pulse = done;
    res.press_count       = series_count_nxt;
    res.hold_pulse        = hold_fire;
    res.single_click      = done && (series_count_nxt == 8'd1);
    res.double_click      = done && (series_count_nxt == 8'd2);
    res.triple_click      = done && (series_count_nxt == 8'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_level_r     <= 1'b0;
      series_active_r    <= 1'b0;
      hold_active_r      <= 1'b0;
      last_change_time_r <= '0;
      last_press_time_r  <= '0;
      series_count_r     <= '0;
    end else if (advance) begin
      stable_level_r     <= stable_level_nxt;
      series_active_r    <= series_active_nxt;
      hold_active_r      <= hold_active_nxt;
      last_change_time_r <= last_change_time_nxt;
      last_press_time_r  <= last_press_time_nxt;
      series_count_r     <= series_count_nxt;
    end
  end

  a_hold_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    hold_active_r |-> stable_level_r)
    else $error("hold active while released");

  a_hold_ends_series: assert property (@(posedge clk) disable iff (!rst_n)
    hold_active_r |-> !series_active_r)
    else $error("series still active during hold");

  a_press_counts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && press |=> series_count_r != '0)
    else $error("press left count at zero");

  a_change_time: assert property (@(posedge clk) disable iff (!rst_n)
    advance && chg |=> last_change_time_r == $past(item.now_ms))
    else $error("change time not captured");

endmodule

FILE: rtl/button_debounce_click_hold.sv
// Debounces an active-low button and reports press, release, click, hold and
// multi-click series events. Each input request carries one raw pin sample and
// a wrapping millisecond timestamp; each produces exactly one result request.
// Results pass the input register, then the result register, and the block
// takes one request per clock when the output is drained, since all the
// arithmetic is two 32-bit subtracts and a few compares on the state
// registers. Configuration writes take effect on the next request and are
// meant to be done while no request is in flight.
module button_debounce_click_hold (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] pin_level, [32:1] now_ms, rest zero
  input  logic [bdch_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] is_pressed, [1] press_pulse, [2] release_pulse, [3] click_pulse,
  // [4] series_done_pulse, [12:5] press_count, [13] hold_pulse,
  // [14] single_click, [15] double_click, [16] triple_click, rest zero
  output logic [bdch_pkg::OutDataW-1:0]  out_tdata,
  input  logic                           cfg_we,
  input  logic [bdch_pkg::AddrW-1:0]     cfg_addr,
  input  logic [bdch_pkg::CfgW-1:0]      cfg_wdata
);

  bdch_pkg::cfg_t    cfg_r;
  bdch_pkg::cfg_t    cfg_nxt;
  bdch_pkg::item_t   item;
  bdch_pkg::result_t res;
  bdch_pkg::result_t res_r;
  logic              s1_valid;
  logic              out_free;
  logic              advance;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        bdch_pkg::RegDebounce: cfg_nxt.debounce_ms           = cfg_wdata;
        bdch_pkg::RegWindow:   cfg_nxt.multi_click_window_ms = cfg_wdata;
        bdch_pkg::RegHold:     cfg_nxt.hold_time_ms          = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms           <= bdch_pkg::DebounceRst;
      cfg_r.multi_click_window_ms <= bdch_pkg::WindowRst;
      cfg_r.hold_time_ms          <= bdch_pkg::HoldRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign advance  = s1_valid && out_free;

  bdch_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .valid     (s1_valid),
    .item      (item)
  );

  bdch_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bdch_pkg::OutDataW - $bits(bdch_pkg::result_t)){1'b0}}, res_r};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !advance)
    else $error("result overwritten while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced request produced no result");

  a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res.single_click || res.double_click || res.triple_click)
    |=> res_r.series_done_pulse)
    else $error("click flag without series done");

endmodule

FILE: test/tb_button_debounce_click_hold.sv
`timescale 1ns / 1ps

module tb_button_debounce_click_hold;

  localparam logic [bdch_pkg::AddrW-1:0] RegUnused = 2'd3;
  localparam int ItemsTarget = 2000;
  localparam int StallLimit  = 3000;
  localparam int HoldOffCycles = 300;

  class click_scoreboard;
    logic [bdch_pkg::CfgW-1:0]   debounce_ms;
    logic [bdch_pkg::CfgW-1:0]   window_ms;
    logic [bdch_pkg::CfgW-1:0]   hold_ms;
    logic                        stable_level;
    logic                        series_active;
    logic                        hold_active;
    logic [bdch_pkg::TimeW-1:0]  last_change_ms;
    logic [bdch_pkg::TimeW-1:0]  last_press_ms;
    logic [bdch_pkg::CountW-1:0] series_count;
    bdch_pkg::result_t           predicted_results[$];
    int errors;
    int n_presses, n_holds, n_clicks, n_singles, n_doubles, n_triples, n_saturated;

    function new();
      debounce_ms    = bdch_pkg::DebounceRst;
      window_ms      = bdch_pkg::WindowRst;
      hold_ms        = bdch_pkg::HoldRst;
      stable_level   = 1'b0;
      series_active  = 1'b0;
      hold_active    = 1'b0;
      last_change_ms = '0;
      last_press_ms  = '0;
      series_count   = '0;
    endfunction

    function void write_reg(logic [bdch_pkg::AddrW-1:0] idx, logic [bdch_pkg::CfgW-1:0] value);
      case (idx)
        bdch_pkg::RegDebounce: debounce_ms = value;
        bdch_pkg::RegWindow:   window_ms = value;
        bdch_pkg::RegHold:     hold_ms = value;
        default: ;
      endcase
    endfunction

    function void note_sample(logic pin, logic [bdch_pkg::TimeW-1:0] now);
      bdch_pkg::result_t r;
      logic pressed_raw;
      logic [bdch_pkg::TimeW-1:0] since_change, since_press;
      r = '0;
      pressed_raw = ~pin;
      since_change = now - last_change_ms;
      if (stable_level != pressed_raw &&
          since_change >= bdch_pkg::TimeW'(debounce_ms)) begin
        stable_level = pressed_raw;
        last_change_ms = now;
        if (stable_level) begin
          r.press_pulse = 1'b1;
          series_active = 1'b1;
          since_press = now - last_press_ms;
          if (since_press <= bdch_pkg::TimeW'(window_ms)) begin
            if (series_count < bdch_pkg::CountMax)
              series_count = series_count + bdch_pkg::CountW'(1);
          end else begin
            series_count = bdch_pkg::CountW'(1);
          end
          last_press_ms = now;
        end else begin
          r.release_pulse = 1'b1;
          r.click_pulse = ~hold_active;
        end
        hold_active = 1'b0;
      end
      since_press = now - last_press_ms;
      if (!stable_level && series_active && since_press > bdch_pkg::TimeW'(window_ms)) begin
        series_active = 1'b0;
        r.series_done_pulse = 1'b1;
      end
      since_change = now - last_change_ms;
      if (stable_level && !hold_active && since_change >= bdch_pkg::TimeW'(hold_ms)) begin
        series_active = 1'b0;
        hold_active = 1'b1;
        r.hold_pulse = 1'b1;
      end
      r.is_pressed   = stable_level;
      r.press_count  = series_count;
      r.single_click = r.series_done_pulse && series_count == 1;
      r.double_click = r.series_done_pulse && series_count == 2;
      r.triple_click = r.series_done_pulse && series_count == 3;
      predicted_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [bdch_pkg::OutDataW-1:0] raw);
      bdch_pkg::result_t got, exp_r;
      got = bdch_pkg::result_t'(raw[$bits(bdch_pkg::result_t)-1:0]);
      if (predicted_results.size() == 0) begin
        errors++;
        $display("%0t: result %h with no request outstanding, expected none", $time, raw);
        return;
      end
      exp_r = predicted_results.pop_front();
      compare_field("is_pressed", exp_r.is_pressed, got.is_pressed);
      compare_field("press_pulse", exp_r.press_pulse, got.press_pulse);
      compare_field("release_pulse", exp_r.release_pulse, got.release_pulse);
      compare_field("click_pulse", exp_r.click_pulse, got.click_pulse);
      compare_field("series_done_pulse", exp_r.series_done_pulse, got.series_done_pulse);
      compare_field("press_count", exp_r.press_count, got.press_count);
      compare_field("hold_pulse", exp_r.hold_pulse, got.hold_pulse);
      compare_field("single_click", exp_r.single_click, got.single_click);
      compare_field("double_click", exp_r.double_click, got.double_click);
      compare_field("triple_click", exp_r.triple_click, got.triple_click);
      compare_field("padding", '0,
                    8'(raw[bdch_pkg::OutDataW-1:$bits(bdch_pkg::result_t)]));
      n_presses   += exp_r.press_pulse;
      n_holds     += exp_r.hold_pulse;
      n_clicks    += exp_r.click_pulse;
      n_singles   += exp_r.single_click;
      n_doubles   += exp_r.double_click;
      n_triples   += exp_r.triple_click;
      n_saturated += (exp_r.press_pulse && exp_r.press_count == bdch_pkg::CountMax);
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [bdch_pkg::InDataW-1:0]  in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [bdch_pkg::OutDataW-1:0] out_tdata;
  logic                          cfg_we;
  logic [bdch_pkg::AddrW-1:0]    cfg_addr;
  logic [bdch_pkg::CfgW-1:0]     cfg_wdata;

  click_scoreboard sb = new();
  logic [bdch_pkg::TimeW-1:0] t_ms;
  int n_sent;
  int stall_cycles;
  bit no_idle;
  bit hold_req;

  button_debounce_click_hold dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
      end
      out_tready <= no_idle || $urandom_range(99) >= 36;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: timeout, no request moved for %0d cycles", $time, StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic pin, input logic [bdch_pkg::TimeW-1:0] now);
    while (!no_idle && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(bdch_pkg::InDataW - bdch_pkg::TimeW - 1){1'b0}}, now, pin};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(pin, now);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [bdch_pkg::AddrW-1:0] idx,
                           input logic [bdch_pkg::CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [bdch_pkg::CfgW-1:0] deb,
                            input logic [bdch_pkg::CfgW-1:0] win,
                            input logic [bdch_pkg::CfgW-1:0] hld);
    write_reg(bdch_pkg::RegDebounce, deb);
    write_reg(bdch_pkg::RegWindow, win);
    write_reg(bdch_pkg::RegHold, hld);
    cfg_we <= 1'b0;
  endtask

  // wait until every predicted result has come back, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.predicted_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic sample(input logic pin, input int unsigned max_dt);
    t_ms = t_ms + $urandom_range(0, max_dt);
    send_item(pin, t_ms);
  endtask

  // keep the pin at one level for about span ms, sampled at random steps
  task automatic dwell(input logic pin, input int unsigned span, input int unsigned step);
    int unsigned el;
    el = 0;
    do begin
      int unsigned dt;
      dt = $urandom_range(1, step);
      t_ms = t_ms + dt;
      el = el + dt;
      send_item(pin, t_ms);
    end while (el < span);
  endtask

  task automatic gesture();
    int unsigned deb, win, hld, step, span;
    deb = sb.debounce_ms;
    win = sb.window_ms;
    hld = sb.hold_ms;
    step = (deb + win + hld) / 24 + 1;
    // contact chatter around each edge
    repeat ($urandom_range(0, 3)) sample(1'($urandom_range(0, 1)), deb / 3 + 1);
    case ($urandom_range(0, 2))
      0: span = $urandom_range(0, hld / 2 + deb + 1);
      1: span = $urandom_range(hld / 2, hld + deb + 2);
      default: span = $urandom_range(hld, 2 * hld + deb + 8);
    endcase
    dwell(1'b0, span, step);
    repeat ($urandom_range(0, 3)) sample(1'($urandom_range(0, 1)), deb / 3 + 1);
    case ($urandom_range(0, 2))
      0: span = $urandom_range(0, win / 2 + deb + 1);
      1: span = $urandom_range(win / 2, win + deb + 2);
      default: span = $urandom_range(win, 2 * win + deb + 8);
    endcase
    dwell(1'b1, span, step);
  endtask

  // quick clicks inside the window, then a pause long enough to end the series
  task automatic click_burst();
    int unsigned deb, win, step;
    deb = sb.debounce_ms;
    win = sb.window_ms;
    step = deb / 2 + 1;
    repeat ($urandom_range(2, 4)) begin
      dwell(1'b0, deb + $urandom_range(0, win / 4 + 1), step);
      dwell(1'b1, deb + $urandom_range(0, win / 4 + 1), step);
    end
    dwell(1'b1, win + deb + 2, win / 4 + 1);
  endtask

  task automatic noise_item();
    if ($urandom_range(0, 3) == 0) begin
      send_item(1'($urandom_range(0, 1)), $urandom());
    end else begin
      sample(1'($urandom_range(0, 1)), $urandom_range(0, 64));
    end
  endtask

  initial begin
    int target;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    n_sent     = 0;
    t_ms       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, first press right after reset counts as one
    send_item(1'b1, 32'd0);
    send_item(1'b0, 32'd50);
    send_item(1'b1, 32'd60);
    send_item(1'b0, 32'd70);
    send_item(1'b0, 32'd850);    // hold reached, series dropped
    send_item(1'b1, 32'd900);    // release ending a hold: no click
    send_item(1'b1, 32'd2000);
    send_item(1'b0, 32'd2100);
    send_item(1'b1, 32'd2200);
    send_item(1'b0, 32'd2300);
    send_item(1'b1, 32'd2400);
    send_item(1'b0, 32'd2500);
    send_item(1'b1, 32'd2600);
    send_item(1'b1, 32'd2901);   // triple series done
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b1, 32'd0);      // bounce across the wrap
    send_item(1'b1, 32'd64);
    drain();
    // zero hold time: hold fires on the press sample itself
    set_config(16'd0, 16'd0, 16'd0);
    send_item(1'b0, 32'd100);
    send_item(1'b1, 32'd101);
    send_item(1'b1, 32'd102);
    drain();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 32'h0002_0000);
    send_item(1'b1, 32'h0002_FFFE);
    send_item(1'b1, 32'h0002_FFFF);
    drain();

    // realistic use at reset settings, with one long result-side hold-off
    write_reg(RegUnused, bdch_pkg::CfgW'($urandom_range(0, 65535)));
    set_config(bdch_pkg::DebounceRst, bdch_pkg::WindowRst, bdch_pkg::HoldRst);
    t_ms = $urandom();
    target = n_sent + 300;
    hold_req = 1'b1;
    while (n_sent < target) begin
      if ($urandom_range(99) < 60) gesture(); else click_burst();
    end
    drain();

    // fast clicking far past the count limit, no idling on either side
    set_config(16'd0, 16'hFFFF, 16'hFFFF);
    no_idle = 1'b1;
    repeat (270) begin
      if ($urandom_range(0, 9) == 0) sample(1'($urandom_range(0, 1)), 3);
      sample(1'b0, 20);
      sample(1'b1, 20);
    end
    no_idle = 1'b0;
    drain();

    // largest settings across the timestamp wrap
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    t_ms = 32'hFFFE_0000;
    repeat (12) gesture();
    drain();

    while (n_sent < ItemsTarget) begin
      drain();
      case ($urandom_range(0, 3))
        0: set_config(bdch_pkg::CfgW'($urandom_range(0, 65535)),
                      bdch_pkg::CfgW'($urandom_range(0, 65535)),
                      bdch_pkg::CfgW'($urandom_range(0, 65535)));
        default: set_config(bdch_pkg::CfgW'($urandom_range(0, 30)),
                            bdch_pkg::CfgW'($urandom_range(0, 300)),
                            bdch_pkg::CfgW'($urandom_range(0, 500)));
      endcase
      if ($urandom_range(0, 2) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      target = n_sent + 150;
      while (n_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1: noise_item();
          2, 3, 4: click_burst();
          default: gesture();
        endcase
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Ran %0d samples: %0d presses, %0d clicks, %0d holds, count saturated %0d times",
             n_sent, sb.n_presses, sb.n_clicks, sb.n_holds, sb.n_saturated);
    $display("Series done: %0d single, %0d double, %0d triple",
             sb.n_singles, sb.n_doubles, sb.n_triples);
    if (sb.errors == 0 && sb.predicted_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.predicted_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
